[hw/rtl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// Circular deque package
// Sizes, request and status codes, and the controller-to-datapath command
// bundle shared by the deque modules.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int OUT_DATA_W = 32;
   localparam int OUT_CNT_W  = 5;

   typedef logic [1:0] req_kind_type;
   typedef logic [1:0] status_type;

   localparam req_kind_type REQ_PUSH_FRONT = 2'd0;
   localparam req_kind_type REQ_PUSH_REAR  = 2'd1;
   localparam req_kind_type REQ_POP_FRONT  = 2'd2;
   localparam req_kind_type REQ_POP_REAR   = 2'd3;

   localparam status_type STAT_OK         = 2'd0;
   localparam status_type STAT_FULL       = 2'd1;
   localparam status_type STAT_EMPTY      = 2'd2;

   typedef struct packed {
      logic issue;
      logic respond;
   } cdq_cmd_type;

endpackage

[hw/rtl/circular_deque.sv]
// ----------------------------------------------------------------------------
// Circular deque
// Double-ended queue in a ring RAM: push or pop at either end, one response
// per request with data, status, empty, full and fill count.
//
//   Channel   Handshake              Contents
//   request   start high, busy low   req_type, req_push_value
//   response  rsp_valid (strobe)     rsp_data_out, rsp_status, rsp_now_empty,
//                                    rsp_now_full, rsp_fill_count
//
// For each request, the ring RAM is written or read in the cycle
// it is taken, and the response strobes in the next cycle while busy is high.
// A new request can be taken the cycle after the strobe.
// Reset is synchronous and clears the indices and count; the RAM is not
// cleared, as only written entries are ever read.
// The receiver cannot stall; each response is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module circular_deque (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  cdq_pkg::req_kind_type  req_type,
   input  logic [31:0]            req_push_value,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_data_out,
   output cdq_pkg::status_type    rsp_status,
   output logic                   rsp_now_empty,
   output logic                   rsp_now_full,
   output logic [4:0]             rsp_fill_count
);
   import cdq_pkg::*;

   cdq_cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   cdq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty),
      .rsp_now_full   (rsp_now_full),
      .rsp_fill_count (rsp_fill_count)
   );

   // Every accepted request produces its response in the following cycle.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("request accepted without a response in the next cycle");

   a_resp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_resp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response presented while a new request could be taken");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL || rsp_status == STAT_EMPTY)
         |-> rsp_data_out == '0)
      else $error("refused request returned non-zero data");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_now_empty && rsp_now_full))
      else $error("queue reported empty and full together");

endmodule

[hw/rtl/cdq_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle at a shared address, registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// Circular deque controller
// Takes a request when idle and holds busy for the cycle in which the
// response is presented.
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output cdq_pkg::cdq_cmd_type cmd
);
   import cdq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff == ST_RESP);
   assign cmd.issue   = start && (state_ff == ST_IDLE);
   assign cmd.respond = (state_ff == ST_RESP);

endmodule

[hw/rtl/cdq_dpath.sv]
// ----------------------------------------------------------------------------
// Circular deque datapath
// Front and rear indices, element count, the ring RAM and the response
// registers.
// ----------------------------------------------------------------------------
module cdq_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  cdq_pkg::cdq_cmd_type     cmd,
   input  cdq_pkg::req_kind_type    req_type,
   input  logic [31:0]              req_push_value,
   output logic                     rsp_valid,
   output logic [31:0]              rsp_data_out,
   output cdq_pkg::status_type      rsp_status,
   output logic                     rsp_now_empty,
   output logic                     rsp_now_full,
   output logic [4:0]               rsp_fill_count
);
   import cdq_pkg::*;

   logic [ADDR_W-1:0]     head_ff, head_in;
   logic [ADDR_W-1:0]     tail_ff, tail_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   status_type            status_ff, status_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic                  from_ram_ff, from_ram_in;

   logic [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0] ram_rd_data;
   logic [DATA_WIDTH-1:0] rsp_word;
   logic [63:0]           rsp_word_wide;
   logic [15:0]           count_wide;
   logic [ADDR_W-1:0]     ram_addr;
   logic                  ram_wr_en;
   logic                  is_push;
   logic                  is_empty;
   logic                  is_full;
   logic [ADDR_W-1:0]     head_up, head_down, tail_up, tail_down;

   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

   assign push_word = DATA_WIDTH'(64'(req_push_value));
   assign is_push   = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_REAR);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == COUNT_W'(DEPTH));

   assign head_up   = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_down = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_up   = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_down = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      status_in   = STAT_OK;
      word_in     = '0;
      from_ram_in = 1'b0;
      ram_addr    = head_ff;
      ram_wr_en   = 1'b0;
      if (is_push) begin
         if (is_full) begin
            status_in = STAT_FULL;
         end else begin
            // A push into an empty queue restarts both ends at entry zero.
            if (is_empty) begin
               head_in  = '0;
               tail_in  = '0;
               ram_addr = '0;
            end else if (req_type == REQ_PUSH_FRONT) begin
               head_in  = head_down;
               ram_addr = head_down;
            end else begin
               tail_in  = tail_up;
               ram_addr = tail_up;
            end
            ram_wr_en = cmd.issue;
            count_in  = count_ff + 1'b1;
            word_in   = push_word;
         end
      end else begin
         if (is_empty) begin
            status_in = STAT_EMPTY;
         end else begin
            if (req_type == REQ_POP_FRONT) begin
               ram_addr = head_ff;
               head_in  = head_up;
            end else begin
               ram_addr = tail_ff;
               tail_in  = tail_down;
            end
            count_in    = count_ff - 1'b1;
            from_ram_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.issue) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         status_ff   <= status_in;
         word_ff     <= word_in;
         from_ram_ff <= from_ram_in;
      end
   end

   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (cmd.issue),
      .addr    (ram_addr),
      .wr_data (push_word),
      .rd_data (ram_rd_data)
   );

   // The count and indices already hold their post-request values here.
   assign rsp_word       = from_ram_ff ? ram_rd_data : word_ff;
   assign rsp_word_wide  = 64'(rsp_word);
   assign count_wide     = 16'(count_ff);
   assign rsp_valid      = cmd.respond;
   assign rsp_data_out   = rsp_word_wide[OUT_DATA_W-1:0];
   assign rsp_status     = status_ff;
   assign rsp_now_empty  = (count_ff == '0);
   assign rsp_now_full   = (count_ff == COUNT_W'(DEPTH));
   assign rsp_fill_count = count_wide[OUT_CNT_W-1:0];

endmodule

[dv/circular_deque_tb.sv]
// ----------------------------------------------------------------------------
// Circular deque testbench
// Sends push and pop requests at both ends of the deque and keeps its own
// copy of the ring, the indices and the count. From that copy it works out
// the response to every request and compares it field by field with what
// the block returns. The run starts with short directed checks: refusals on
// an empty and on a full deque, index wrap at both ends, and restart after
// draining. It then sends random traffic whose push rate moves between
// phases, so the deque fills, drains and wraps many times.
// ----------------------------------------------------------------------------
module circular_deque_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import cdq_pkg::*;

   localparam int IDLE_LIMIT = 500;

   typedef struct packed {
      logic [31:0]   data;
      status_type    status;
      logic          empty;
      logic          full;
      logic [4:0]    count;
   } deque_rsp_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_kind_type  req_type = REQ_PUSH_FRONT;
   logic [31:0]   req_push_value = '0;
   logic          rsp_valid;
   logic [31:0]   rsp_data_out;
   status_type    rsp_status;
   logic          rsp_now_empty;
   logic          rsp_now_full;
   logic [4:0]    rsp_fill_count;

   // Our own copy of the deque.
   logic [DATA_WIDTH-1:0] ring_mirror [DEPTH];
   int            head_ptr;
   int            tail_ptr;
   int            held_count;

   deque_rsp_type rsp_due [$];
   int            idle_pct;
   int            fault_count;
   int            kind_count [4];
   int            full_refusals;
   int            empty_refusals;
   int            times_full;

   circular_deque DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty),
      .rsp_now_full   (rsp_now_full),
      .rsp_fill_count (rsp_fill_count)
   );

   always #2 clock = ~clock;

   function automatic int wrap_up(int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int wrap_down(int i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   // Applies one request to the copy and queues the response it must give.
   function automatic void apply_request(req_kind_type kind, logic [31:0] value);
      deque_rsp_type rsp;
      rsp = '0;
      rsp.status = STAT_OK;
      kind_count[kind]++;
      if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_REAR) begin
         if (held_count >= DEPTH) begin
            rsp.status = STAT_FULL;
            full_refusals++;
         end else begin
            // A push into an empty deque always restarts both ends at entry 0.
            if (held_count == 0) begin
               head_ptr = 0;
               tail_ptr = 0;
               ring_mirror[0] = value;
            end else if (kind == REQ_PUSH_FRONT) begin
               head_ptr = wrap_down(head_ptr);
               ring_mirror[head_ptr] = value;
            end else begin
               tail_ptr = wrap_up(tail_ptr);
               ring_mirror[tail_ptr] = value;
            end
            held_count++;
            rsp.data = value;
            if (held_count == DEPTH) times_full++;
         end
      end else begin
         if (held_count == 0) begin
            rsp.status = STAT_EMPTY;
            empty_refusals++;
         end else if (kind == REQ_POP_FRONT) begin
            rsp.data = ring_mirror[head_ptr];
            head_ptr = wrap_up(head_ptr);
            held_count--;
         end else begin
            rsp.data = ring_mirror[tail_ptr];
            tail_ptr = wrap_down(tail_ptr);
            held_count--;
         end
      end
      rsp.empty = (held_count == 0);
      rsp.full  = (held_count >= DEPTH);
      rsp.count = held_count[4:0];
      rsp_due.push_back(rsp);
   endfunction

   // Sends one request, keeping start high when the next one follows at once.
   task automatic send_request(req_kind_type kind, logic [31:0] value);
      int gap;
      gap = 0;
      while (gap < 8 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_push_value <= value;
      do @(posedge clock); while (busy);
      apply_request(kind, value);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(15))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_refusal();
      send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
      send_request(REQ_POP_REAR, 32'h1234_5678);
      send_request(REQ_PUSH_FRONT, 32'h0000_0000);
      send_request(REQ_POP_REAR, 32'hFFFF_FFFF);
      send_request(REQ_PUSH_REAR, 32'hFFFF_FFFF);
      send_request(REQ_POP_FRONT, 32'h0000_0000);
   endtask

   task automatic test_end_wrap();
      send_request(REQ_PUSH_REAR, 32'hA5A5_A5A5);
      // The front index wraps from 0 to the top entry here.
      send_request(REQ_PUSH_FRONT, 32'h5A5A_5A5A);
      send_request(REQ_PUSH_FRONT, 32'h8000_0001);
      send_request(REQ_PUSH_REAR, 32'h7FFF_FFFE);
      send_request(REQ_POP_REAR, 32'h0);
      send_request(REQ_POP_FRONT, 32'h0);
      send_request(REQ_POP_FRONT, 32'h0);
      send_request(REQ_POP_REAR, 32'h0);
      // Drained with the indices left where they were; the next push restarts.
      send_request(REQ_PUSH_FRONT, 32'hDEAD_BEEF);
      send_request(REQ_POP_FRONT, 32'h0);
   endtask

   task automatic test_full_refusal();
      int i;
      for (i = 0; i < DEPTH; i++)
         send_request($urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT, pick_word());
      send_request(REQ_PUSH_FRONT, pick_word());
      send_request(REQ_PUSH_REAR, pick_word());
      for (i = 0; i < DEPTH; i++)
         send_request($urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT, pick_word());
   endtask

   // Random traffic in stretches with a changing push rate, so that the
   // deque swings between full and empty and both indices wrap often.
   task automatic test_random_traffic(int n);
      int sent;
      int stretch;
      int push_rate;
      logic front;
      sent = 0;
      stretch = 0;
      push_rate = 50;
      while (sent < n) begin
         if (stretch == 0) begin
            stretch = $urandom_range(40, 8);
            case ($urandom_range(4))
               0:       push_rate = 85;
               1:       push_rate = 65;
               2:       push_rate = 50;
               3:       push_rate = 35;
               default: push_rate = 15;
            endcase
         end
         front = 1'($urandom_range(1));
         if ($urandom_range(99) < push_rate)
            send_request(front ? REQ_PUSH_FRONT : REQ_PUSH_REAR, pick_word());
         else
            send_request(front ? REQ_POP_FRONT : REQ_POP_REAR, pick_word());
         stretch--;
         sent++;
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= 10)
            $display("Mismatch on %s: expected %h, got %h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      deque_rsp_type due;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("Response with no request outstanding: data %h status %0d",
                        rsp_data_out, rsp_status);
         end else begin
            due = rsp_due.pop_front();
            check_field("data_out", due.data, rsp_data_out);
            check_field("status", 32'(due.status), 32'(rsp_status));
            check_field("now_empty", 32'(due.empty), 32'(rsp_now_empty));
            check_field("now_full", 32'(due.full), 32'(rsp_now_full));
            check_field("fill_count", 32'(due.count), 32'(rsp_fill_count));
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy && !reset) || rsp_valid)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no request or response for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      head_ptr = 0;
      tail_ptr = 0;
      held_count = 0;
      fault_count = 0;
      full_refusals = 0;
      empty_refusals = 0;
      times_full = 0;
      kind_count = '{default: 0};
      idle_pct = 14;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_refusal();
      test_end_wrap();
      test_full_refusal();
      test_random_traffic(580);
      idle_pct = 47;
      test_random_traffic(600);
      idle_pct = 0;
      test_random_traffic(600);

      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Requests: %0d push front, %0d push rear, %0d pop front, %0d pop rear",
               kind_count[REQ_PUSH_FRONT], kind_count[REQ_PUSH_REAR],
               kind_count[REQ_POP_FRONT], kind_count[REQ_POP_REAR]);
      $display("Deque filled %0d times; %0d pushes refused when full, %0d pops when empty",
               times_full, full_refusals, empty_refusals);
      if (fault_count == 0)
         $display("TEST PASSED");
      else begin
         $display("%0d mismatches in total", fault_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
